FILE: rtl/core/oset_pkg.sv
// Shared types and constants for the one-shot event timer bank.
package oset_pkg;

  // Field and register widths fixed by the block's interface.
  localparam int DELAY_W       = 8;
  localparam int CFG_COUNT     = 8;
  localparam int CFG_IDX_W     = $clog2(CFG_COUNT);
  localparam int EVT_IDX_W     = 3;
  localparam int ACTION_W      = 2;
  localparam int PEND_W        = 8;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 16;

  // Default size of the timer bank.
  localparam int DEFAULT_EVENT_COUNT = 8;

  // Operation codes carried by each input item.
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_ARM    = 2'd1,
    ACT_DISARM = 2'd2,
    ACT_TAKE   = 2'd3
  } action_t;

  // One command handed to the counter bank.
  typedef struct packed {
    logic                 step;
    action_t              action;
    logic [EVT_IDX_W-1:0] event_index;
  } cmd_t;

  // Result of one command.
  typedef struct packed {
    logic [PEND_W-1:0] pending_events;
    logic              tick_running;
  } result_t;

  // Current state of the bank, seen by the top level.
  typedef struct packed {
    logic [PEND_W-1:0] pending;
    logic              ticking;
  } status_t;

endpackage

FILE: rtl/core/oset_counter_bank.sv
// Counter bank: delay registers, down-counters, pending flags and tick enable.
module oset_counter_bank #(
  parameter int EVENT_COUNT = oset_pkg::DEFAULT_EVENT_COUNT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [oset_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [oset_pkg::DELAY_W-1:0]   cfg_wdata,
  input  oset_pkg::cmd_t                 cmd,
  output oset_pkg::result_t              result,
  output oset_pkg::status_t              status
);
  import oset_pkg::*;

  logic [DELAY_W-1:0]     delay_r [EVENT_COUNT];
  logic [DELAY_W-1:0]     rem_r   [EVENT_COUNT];
  logic [DELAY_W-1:0]     rem_nxt [EVENT_COUNT];
  logic [EVENT_COUNT-1:0] pend_r;
  logic [EVENT_COUNT-1:0] pend_nxt;
  logic                   tick_r;
  logic                   tick_nxt;
  logic [EVENT_COUNT-1:0] nonzero;

  // Delay registers; writes to events beyond the bank are dropped.
  always_ff @(posedge clk) begin
    for (int i = 0; i < EVENT_COUNT; i++) begin
      if (!rst_n) begin
        delay_r[i] <= '0;
      end else if (cfg_we && (cfg_index == CFG_IDX_W'(i))) begin
        delay_r[i] <= cfg_wdata;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < EVENT_COUNT; i++) begin
      nonzero[i] = (rem_r[i] != '0);
    end
  end

  // Next state of the counters, pending flags and tick enable.
  always_comb begin
    rem_nxt  = rem_r;
    pend_nxt = pend_r;
    tick_nxt = tick_r;
    if (cmd.step) begin
      unique case (cmd.action)
        ACT_TICK: begin
          if (tick_r) begin
            for (int i = 0; i < EVENT_COUNT; i++) begin
              if (nonzero[i]) begin
                rem_nxt[i] = rem_r[i] - DELAY_W'(1);
                if (rem_r[i] == DELAY_W'(1)) begin
                  pend_nxt[i] = 1'b1;
                end
              end
            end
            if (!(|nonzero)) begin
              tick_nxt = 1'b0;
            end
          end
        end
        ACT_ARM: begin
          for (int i = 0; i < EVENT_COUNT; i++) begin
            if (cmd.event_index == EVT_IDX_W'(i)) begin
              rem_nxt[i] = delay_r[i];
              tick_nxt   = 1'b1;
            end
          end
        end
        ACT_DISARM: begin
          for (int i = 0; i < EVENT_COUNT; i++) begin
            if (cmd.event_index == EVT_IDX_W'(i)) begin
              rem_nxt[i] = '0;
            end
          end
        end
        ACT_TAKE: begin
          pend_nxt = '0;
        end
        default: begin
          pend_nxt = pend_r;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < EVENT_COUNT; i++) begin
        rem_r[i] <= '0;
      end
      pend_r <= '0;
      tick_r <= 1'b0;
    end else begin
      rem_r  <= rem_nxt;
      pend_r <= pend_nxt;
      tick_r <= tick_nxt;
    end
  end

  // Result of the current command and a view of the stored state.
  always_comb begin
    result.pending_events = (cmd.action == ACT_TAKE) ? PEND_W'(pend_r) : '0;
    result.tick_running   = tick_nxt;
    status.pending        = PEND_W'(pend_r);
    status.ticking        = tick_r;
  end

endmodule

FILE: rtl/core/one_shot_event_timer_bank.sv
// A command is held in the input register, and its result then in the result register that
// drives the output. Throughput: one item per cycle unless out_tready stalls the output;
// the result register frees itself in the cycle it is taken.
// Commands update the bank as they leave the input register; a tick steps all live counters.
// Reset (synchronous, rst_n low): counters, pending flags, delays and tick enable clear to zero;
// both stages empty.
// Top level of the one-shot event timer bank.
module one_shot_event_timer_bank #(
  parameter int EVENT_COUNT = oset_pkg::DEFAULT_EVENT_COUNT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [oset_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [oset_pkg::DELAY_W-1:0]     cfg_wdata,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [oset_pkg::IN_TDATA_W-1:0]  in_tdata,   // [1:0] action, [4:2] event_index
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [oset_pkg::OUT_TDATA_W-1:0] out_tdata   // [7:0] pending_events, [8] tick_running
);
  import oset_pkg::*;

  logic                 s1_valid_r;
  action_t              s1_action_r;
  logic [EVT_IDX_W-1:0] s1_index_r;
  logic                 s1_adv;
  logic                 out_valid_r;
  result_t              out_res_r;
  cmd_t                 cmd;
  result_t              res;
  status_t              status;

  // Stage one moves on when the result register is empty or being taken.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_action_r <= action_t'(in_tdata[ACTION_W-1:0]);
      s1_index_r  <= in_tdata[ACTION_W +: EVT_IDX_W];
    end
  end

  always_comb begin
    cmd.step        = s1_adv;
    cmd.action      = s1_action_r;
    cmd.event_index = s1_index_r;
  end

  oset_counter_bank #(
    .EVENT_COUNT(EVENT_COUNT)
  ) u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .result   (res),
    .status   (status)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_res_r.tick_running, out_res_r.pending_events});

  // A take leaves every pending flag clear.
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_action_r == ACT_TAKE)) |=> (status.pending == '0))
    else $error("pending flags not cleared after take");

  // Ticking only stops on a tick command.
  a_stop_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(status.ticking) |-> $past(s1_adv && (s1_action_r == ACT_TICK)))
    else $error("ticking stopped without a tick");

  // The reported run flag matches the stored state once the result lands.
  a_run_flag: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_res_r.tick_running == status.ticking))
    else $error("tick_running disagrees with stored state");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the one-shot event timer bank.
`timescale 1ns / 1ps

module tb;
  import oset_pkg::*;

  localparam int NUM_EVENTS = 8;
  localparam int DRAIN_CYCLES = 4;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DELAY_W-1:0]     cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // [1:0] action, [4:2] event_index
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // [7:0] pending_events, [8] tick_running

  // Shadow copy of the bank: delays, counters, pending flags and tick enable.
  logic [DELAY_W-1:0] delay_shadow [NUM_EVENTS];
  logic [DELAY_W-1:0] ticks_left [NUM_EVENTS];
  logic [PEND_W-1:0]  pending_shadow = '0;
  logic               ticking_shadow = 1'b0;
  logic [DELAY_W-1:0] staged_delay [NUM_EVENTS];

  // Results predicted for accepted commands, oldest first.
  result_t due_results [$];

  int error_count = 0;
  int in_idle_pct = 17;
  int out_idle_pct = 17;

  one_shot_event_timer_bank DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NUM_EVENTS; i++) begin
      delay_shadow[i] = '0;
      ticks_left[i] = '0;
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb: mismatch on %s at %0t: got 0x%0h, expected 0x%0h", what, $realtime, got, want);
    error_count++;
  endtask

  // Apply one accepted command to the shadow bank and queue its result.
  task automatic predict_timer_cmd(input action_t act, input logic [EVT_IDX_W-1:0] idx);
    result_t res;
    logic    any_live;
    res.pending_events = '0;
    case (act)
      ACT_TICK: begin
        if (ticking_shadow) begin
          any_live = 1'b0;
          for (int i = 0; i < NUM_EVENTS; i++) begin
            if (ticks_left[i] != 0) begin
              any_live = 1'b1;
              ticks_left[i] = ticks_left[i] - 1'b1;
              if (ticks_left[i] == 0) pending_shadow[i] = 1'b1;
            end
          end
          if (!any_live) ticking_shadow = 1'b0;
        end
      end
      ACT_ARM: begin
        ticks_left[idx] = delay_shadow[idx];
        ticking_shadow = 1'b1;
      end
      ACT_DISARM: begin
        ticks_left[idx] = '0;
      end
      default: begin
        res.pending_events = pending_shadow;
        pending_shadow = '0;
      end
    endcase
    res.tick_running = ticking_shadow;
    due_results.push_back(res);
  endtask

  // Offer one command, hold it until the transfer, then predict it.
  task automatic send_cmd(input action_t act, input logic [EVT_IDX_W-1:0] idx);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, idx, act};
    do @(posedge clk); while (!in_tready);
    predict_timer_cmd(act, idx);
  endtask

  // Stop sending and wait until every queued result has come back.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all staged delays while the block is idle.
  task automatic load_delays;
    drain();
    for (int i = 0; i < NUM_EVENTS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= staged_delay[i];
      @(posedge clk);
      delay_shadow[i] = staged_delay[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: check each transfer, then pick the next ready value.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 0);
      end else begin
        result_t want;
        want = due_results.pop_front();
        if (out_tdata[7:0] !== want.pending_events)
          report_mismatch("pending_events", out_tdata[7:0], want.pending_events);
        if (out_tdata[8] !== want.tick_running)
          report_mismatch("tick_running", out_tdata[8], want.tick_running);
      end
    end
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic apply_reset;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Ticks, takes and disarms with nothing armed must leave the bank stopped.
  task automatic test_idle_bank;
    send_cmd(ACT_TICK, 3'd0);
    send_cmd(ACT_TAKE, 3'd7);
    send_cmd(ACT_DISARM, 3'd3);
    send_cmd(ACT_TICK, 3'd5);
  endtask

  // Directed corner cases: zero delay, firing, stop, re-arm, disarm, take.
  task automatic test_corner_cases;
    staged_delay = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd128, 8'd5, 8'd254, 8'd255};
    load_delays();
    // A zero delay starts ticking but the next tick stops it again.
    send_cmd(ACT_ARM, 3'd0);
    send_cmd(ACT_TICK, 3'd0);
    send_cmd(ACT_TICK, 3'd0);
    // Event 1 fires after one tick, then ticking stops.
    send_cmd(ACT_ARM, 3'd1);
    send_cmd(ACT_TICK, 3'd0);
    send_cmd(ACT_TICK, 3'd0);
    send_cmd(ACT_TAKE, 3'd0);
    // Re-arming restarts the count from the full delay.
    send_cmd(ACT_ARM, 3'd2);
    send_cmd(ACT_TICK, 3'd0);
    send_cmd(ACT_ARM, 3'd2);
    send_cmd(ACT_TICK, 3'd0);
    send_cmd(ACT_TICK, 3'd0);
    // Disarm clears the counter but keeps ticking and pending flags.
    send_cmd(ACT_ARM, 3'd3);
    send_cmd(ACT_DISARM, 3'd3);
    send_cmd(ACT_ARM, 3'd5);
    send_cmd(ACT_TAKE, 3'd0);
    send_cmd(ACT_TICK, 3'd0);
    send_cmd(ACT_DISARM, 3'd5);
    send_cmd(ACT_TICK, 3'd0);
    // Leave the longest delays running for the next test.
    send_cmd(ACT_ARM, 3'd7);
    send_cmd(ACT_ARM, 3'd6);
    send_cmd(ACT_ARM, 3'd4);
    send_cmd(ACT_TAKE, 3'd0);
  endtask

  // Tick the largest delays down toward zero, with occasional takes.
  task automatic test_long_delays;
    for (int n = 0; n < 280; n++) begin
      if ($urandom_range(99) < 92) send_cmd(ACT_TICK, EVT_IDX_W'($urandom_range(7)));
      else send_cmd(ACT_TAKE, EVT_IDX_W'($urandom_range(7)));
    end
    send_cmd(ACT_TAKE, 3'd0);
  endtask

  // Random command mix over several delay settings.
  task automatic test_random_mix;
    int pick;
    for (int phase = 0; phase < 8; phase++) begin
      for (int i = 0; i < NUM_EVENTS; i++) begin
        pick = $urandom_range(99);
        if (phase == 0) staged_delay[i] = 8'd0;
        else if (phase == 1) staged_delay[i] = 8'd255;
        else if (pick < 80) staged_delay[i] = DELAY_W'($urandom_range(9));
        else if (pick < 90) staged_delay[i] = 8'd255;
        else staged_delay[i] = DELAY_W'($urandom_range(255));
      end
      load_delays();
      // One phase runs with no idling on either side.
      in_idle_pct  = (phase == 4) ? 0 : 17;
      out_idle_pct = (phase == 4) ? 0 : 17;
      for (int n = 0; n < 200; n++) begin
        pick = $urandom_range(99);
        if (pick < 50) send_cmd(ACT_TICK, EVT_IDX_W'($urandom_range(7)));
        else if (pick < 75) send_cmd(ACT_ARM, EVT_IDX_W'($urandom_range(7)));
        else if (pick < 85) send_cmd(ACT_DISARM, EVT_IDX_W'($urandom_range(7)));
        else send_cmd(ACT_TAKE, EVT_IDX_W'($urandom_range(7)));
      end
    end
    in_idle_pct  = 17;
    out_idle_pct = 17;
  endtask

  initial begin
    apply_reset();
    test_idle_bank();
    test_corner_cases();
    test_long_delays();
    test_random_mix();
    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/oset_pkg.sv
rtl/core/oset_counter_bank.sv
rtl/core/one_shot_event_timer_bank.sv
tb/sv/tb.sv
